@@ src/glc_pkg.sv @@
package glc_pkg;

	localparam int ENTRY_COUNT = 256;
	localparam int HASH_SLOTS  = 64;
	localparam int IDX_W       = $clog2(ENTRY_COUNT);
	localparam int SLOT_W      = $clog2(HASH_SLOTS);
	localparam int KEY_W       = 128;
	localparam int DATA_W      = 40;

	typedef enum logic [1:0] {
		OP_LOOKUP  = 2'd0,
		OP_UPDATE  = 2'd1,
		OP_REBUILD = 2'd2,
		OP_NONE    = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		REG_RESERVED = 2'd0,
		REG_ROW      = 2'd1
	} reg_idx_t;

	typedef enum logic [12:0] {
		S_IDLE  = 13'b0000000000001,
		S_HEAD  = 13'b0000000000010,
		S_CMP   = 13'b0000000000100,
		S_MISS  = 13'b0000000001000,
		S_POP   = 13'b0000000010000,
		S_HIT   = 13'b0000000100000,
		S_LINK  = 13'b0000001000000,
		S_LINK2 = 13'b0000010000000,
		S_REP   = 13'b0000100000000,
		S_OUT   = 13'b0001000000000,
		S_DIV   = 13'b0010000000000,
		S_SWEEP = 13'b0100000000000,
		S_UPD   = 13'b1000000000000
	} state_t;

endpackage

@@ src/glyph_cache_hash_lru_table.sv @@
// Glyph atlas cache table with hashed chains, a free list and a recency list.
// Input stream s_axis: tuser carries the opcode (lookup, update, rebuild, none);
// tdata carries the key and update values. One result per input on m_axis.
// Configuration: cfg channel, index 0 reserved tile count, 1 tiles per row;
// write it only while the block is idle.
// A lookup walks the hash chain of its slot; a miss takes an entry from the
// free list, or reports the table full when the list is empty. A rebuild
// runs the row division, then the table sweep, then sends its result.
// The chain walk takes one key memory read per entry.
// Work is one item at a time: tready is high only in the idle state, entered
// as each result is registered, and a result is held in the output register until
// taken, while the next item may already be accepted.
// After reset the block runs the same division and sweep as a
// rebuild (no result is sent) and accepts no item until it is done.
// A stalled receiver holds the finishing item in its last state until
// the output register frees up.
module glyph_cache_hash_lru_table
	import glc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// key_low, key_high, target_entry, new_fill_state, new_width, new_height
	input  logic [175:0] s_axis_tdata,
	// opcode
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// entry_index, tile_x, tile_y, fill_state, glyph_width, glyph_height
	output logic [79:0]  m_axis_tdata,
	// was_hit, table_full
	output logic [1:0]   m_axis_tuser,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [15:0]  cfg_data
);

	state_t state_q;
	logic [15:0] rtc_q, tpr_q, row;
	logic [IDX_W-1:0] idx_q, head_q, head2_q, free_q, mru_q;
	logic [SLOT_W-1:0] slot_q;
	logic [KEY_W-1:0] key_q;
	logic [DATA_W-1:0] upd_q;
	logic hit_q, full_q, zero_q, emit_q;
	logic [IDX_W:0] steps_q, cnt_q;
	logic [15:0] dvd_q, rem_q, x_q, y_q, xe, ye;
	logic [16:0] rtry;
	logic [4:0] dcnt_q;

	// memories
	logic [IDX_W-1:0] head_mem [HASH_SLOTS];
	logic [KEY_W-1:0] key_mem [ENTRY_COUNT];
	logic [IDX_W-1:0] chain_mem [ENTRY_COUNT];
	logic [IDX_W-1:0] rn_mem [ENTRY_COUNT];
	logic [IDX_W-1:0] rp_mem [ENTRY_COUNT];
	logic [31:0] tile_mem [ENTRY_COUNT];
	logic [DATA_W-1:0] data_mem [ENTRY_COUNT];

	logic head_we, key_we, chain_we, rn_we, rp_we, tile_we, data_we;
	logic [SLOT_W-1:0] head_wa, head_ra;
	logic [IDX_W-1:0] head_wd, head_rd;
	logic [IDX_W-1:0] key_wa, chain_wa, rn_wa, rp_wa, tile_wa, data_wa, walk_ra;
	logic [IDX_W-1:0] chain_wd, rn_wd, rp_wd, chain_rd, rn_rd, rp_rd;
	logic [KEY_W-1:0] key_rd;
	logic [31:0] tile_wd, tile_rd;
	logic [DATA_W-1:0] data_wd, data_rd;
	logic key_eq, s_acc;

	assign row = (tpr_q == 16'd0) ? 16'd1 : tpr_q;
	assign s_axis_tready = (state_q == S_IDLE);
	assign s_acc = s_axis_tvalid && s_axis_tready;
	assign cfg_ready = 1'b1;
	assign key_eq = (key_rd == key_q);
	assign rtry = {rem_q, dvd_q[15]};
	assign xe = (x_q >= row) ? 16'd0 : x_q;
	assign ye = (x_q >= row) ? y_q + 16'd1 : y_q;
	assign head_ra = s_axis_tdata[SLOT_W-1:0];

	always_ff @(posedge clk) begin
		if (head_we) head_mem[head_wa] <= head_wd;
		head_rd <= head_mem[head_ra];
		if (key_we) key_mem[key_wa] <= key_q;
		key_rd <= key_mem[walk_ra];
		if (chain_we) chain_mem[chain_wa] <= chain_wd;
		chain_rd <= chain_mem[walk_ra];
		if (rn_we) rn_mem[rn_wa] <= rn_wd;
		rn_rd <= rn_mem[idx_q];
		if (rp_we) rp_mem[rp_wa] <= rp_wd;
		rp_rd <= rp_mem[idx_q];
		if (tile_we) tile_mem[tile_wa] <= tile_wd;
		tile_rd <= tile_mem[idx_q];
		if (data_we) data_mem[data_wa] <= data_wd;
		data_rd <= data_mem[idx_q];
	end

	always_comb begin
		head_we = 1'b0; key_we = 1'b0; chain_we = 1'b0; rn_we = 1'b0;
		rp_we = 1'b0; tile_we = 1'b0; data_we = 1'b0;
		head_wa = slot_q; head_wd = idx_q;
		key_wa = idx_q; chain_wa = idx_q; chain_wd = head_q;
		rn_wa = idx_q; rn_wd = mru_q; rp_wa = idx_q; rp_wd = '0;
		tile_wa = cnt_q[IDX_W-1:0]; tile_wd = {ye, xe};
		data_wa = idx_q; data_wd = upd_q;
		walk_ra = idx_q;
		case (state_q)
			S_HEAD: walk_ra = head_rd;
			S_CMP: walk_ra = chain_rd;
			S_MISS: walk_ra = free_q;
			S_POP: begin
				head_we = 1'b1; key_we = 1'b1; chain_we = 1'b1;
			end
			S_HIT: begin
				rn_we = 1'b1; rn_wa = rp_rd; rn_wd = rn_rd;
				rp_we = 1'b1; rp_wa = rn_rd; rp_wd = rp_rd;
			end
			S_LINK: begin
				rn_we = 1'b1; rp_we = 1'b1;
			end
			S_LINK2: begin
				rp_we = 1'b1; rp_wa = head2_q; rp_wd = idx_q;
			end
			S_UPD: data_we = 1'b1;
			S_SWEEP: begin
				head_we = (cnt_q < (IDX_W+1)'(HASH_SLOTS));
				head_wa = cnt_q[SLOT_W-1:0]; head_wd = '0;
				chain_we = 1'b1; chain_wa = cnt_q[IDX_W-1:0];
				chain_wd = cnt_q[IDX_W-1:0] + IDX_W'(1);
				rn_we = 1'b1; rn_wa = cnt_q[IDX_W-1:0]; rn_wd = '0;
				rp_we = 1'b1; rp_wa = cnt_q[IDX_W-1:0];
				tile_we = 1'b1;
				data_we = 1'b1; data_wa = cnt_q[IDX_W-1:0]; data_wd = '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rtc_q <= '0;
			tpr_q <= 16'd16;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_RESERVED: rtc_q <= cfg_data;
				REG_ROW: tpr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// payload of the accepted item
	always_ff @(posedge clk) begin
		if (s_acc) begin
			key_q  <= s_axis_tdata[127:0];
			slot_q <= s_axis_tdata[SLOT_W-1:0];
			upd_q  <= {s_axis_tdata[175:160], s_axis_tdata[159:144], s_axis_tdata[143:136]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_DIV;
			emit_q <= 1'b0;
			idx_q <= '0; head_q <= '0; head2_q <= '0; free_q <= '0; mru_q <= '0;
			hit_q <= 1'b0; full_q <= 1'b0; zero_q <= 1'b0;
			steps_q <= '0; cnt_q <= '0;
			dvd_q <= '0; rem_q <= '0; dcnt_q <= '0; x_q <= '0; y_q <= '0;
			m_axis_tvalid <= 1'b0;
			m_axis_tdata <= '0;
			m_axis_tuser <= '0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
			case (state_q)
				S_IDLE: if (s_acc) begin
					hit_q <= 1'b0; full_q <= 1'b0; zero_q <= 1'b0;
					steps_q <= '0;
					idx_q <= s_axis_tdata[135:128];
					case (s_axis_tuser)
						OP_LOOKUP: state_q <= S_HEAD;
						OP_UPDATE: state_q <= S_UPD;
						OP_REBUILD: begin
							emit_q <= 1'b1; zero_q <= 1'b1;
							dvd_q <= rtc_q; rem_q <= '0; dcnt_q <= '0;
							state_q <= S_DIV;
						end
						default: begin
							zero_q <= 1'b1;
							state_q <= S_OUT;
						end
					endcase
				end
				S_HEAD: begin
					head_q <= head_rd;
					idx_q <= head_rd;
					state_q <= (head_rd == '0) ? S_MISS : S_CMP;
				end
				S_CMP: begin
					if (key_eq) begin
						hit_q <= 1'b1;
						state_q <= S_HIT;
					end else if (chain_rd == '0 || steps_q == (IDX_W+1)'(ENTRY_COUNT - 1)) begin
						state_q <= S_MISS;
					end else begin
						idx_q <= chain_rd;
						steps_q <= steps_q + (IDX_W+1)'(1);
					end
				end
				S_MISS: begin
					idx_q <= free_q;
					if (free_q == '0) begin
						full_q <= 1'b1; zero_q <= 1'b1;
						state_q <= S_OUT;
					end else begin
						state_q <= S_POP;
					end
				end
				S_POP: begin
					free_q <= chain_rd;
					state_q <= S_LINK;
				end
				S_HIT: begin
					if (rp_rd == '0) mru_q <= rn_rd;
					state_q <= S_LINK;
				end
				S_LINK: begin
					head2_q <= mru_q;
					mru_q <= idx_q;
					state_q <= S_LINK2;
				end
				S_LINK2: state_q <= S_REP;
				S_UPD: state_q <= S_REP;
				S_REP: state_q <= S_OUT;
				S_OUT: if (!m_axis_tvalid || m_axis_tready) begin
					m_axis_tvalid <= 1'b1;
					m_axis_tuser <= {full_q, hit_q};
					m_axis_tdata <= zero_q ? '0 : {data_rd[39:24], data_rd[23:8],
						data_rd[7:0], tile_rd[31:16], tile_rd[15:0], idx_q};
					state_q <= S_IDLE;
				end
				S_DIV: begin
					// restoring divide of the reserved count by the row width
					if (dcnt_q == 5'd16) begin
						x_q <= rem_q; y_q <= dvd_q;
						cnt_q <= '0;
						state_q <= S_SWEEP;
					end else begin
						dcnt_q <= dcnt_q + 5'd1;
						if (rtry >= {1'b0, row}) begin
							rem_q <= 16'(rtry - {1'b0, row});
							dvd_q <= {dvd_q[14:0], 1'b1};
						end else begin
							rem_q <= rtry[15:0];
							dvd_q <= {dvd_q[14:0], 1'b0};
						end
					end
				end
				S_SWEEP: begin
					x_q <= xe + 16'd1;
					y_q <= ye;
					cnt_q <= cnt_q + (IDX_W+1)'(1);
					if (cnt_q == (IDX_W+1)'(ENTRY_COUNT - 1)) begin
						free_q <= IDX_W'(1);
						mru_q <= '0;
						state_q <= emit_q ? S_OUT : S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_POP |-> idx_q != '0)
		else $error("allocated the sentinel entry");
	assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> !s_axis_tready)
		else $error("accepted a second item while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SWEEP |-> cnt_q < (IDX_W+1)'(ENTRY_COUNT))
		else $error("sweep ran past the table");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_HIT |-> $past(key_eq))
		else $error("relink without key match");

endmodule

@@ verif/tb_glyph_cache_hash_lru_table.sv @@
module tb_glyph_cache_hash_lru_table;
	import glc_pkg::*;

	localparam int CYCLE_LIMIT = 1500000;

	typedef struct packed {
		opcode_t     op;
		logic [63:0] klo;
		logic [63:0] khi;
		logic [7:0]  tgt;
		logic [7:0]  fill;
		logic [15:0] w;
		logic [15:0] h;
	} glyph_req_t;

	typedef struct packed {
		logic [7:0]  idx;
		logic        hit;
		logic        full;
		logic [15:0] tx;
		logic [15:0] ty;
		logic [7:0]  fill;
		logic [15:0] w;
		logic [15:0] h;
	} glyph_res_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	// key_low, key_high, target_entry, new_fill_state, new_width, new_height
	logic [175:0] s_axis_tdata = '0;
	// opcode
	logic [1:0]   s_axis_tuser = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	// entry_index, tile_x, tile_y, fill_state, glyph_width, glyph_height
	logic [79:0]  m_axis_tdata;
	// was_hit, table_full
	logic [1:0]   m_axis_tuser;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [1:0]   cfg_index = '0;
	logic [15:0]  cfg_data = '0;

	glyph_cache_hash_lru_table DUT (.*);

	always #5 clk = ~clk;

	// cache mirror
	logic [7:0]  heads [HASH_SLOTS];
	logic [63:0] key_lo_mem [ENTRY_COUNT];
	logic [63:0] key_hi_mem [ENTRY_COUNT];
	logic [7:0]  chain_link [ENTRY_COUNT];
	logic [7:0]  mru_next [ENTRY_COUNT];
	logic [7:0]  mru_prev [ENTRY_COUNT];
	logic [31:0] tile_pos [ENTRY_COUNT];
	logic [7:0]  fill_mem [ENTRY_COUNT];
	logic [15:0] width_mem [ENTRY_COUNT];
	logic [15:0] height_mem [ENTRY_COUNT];
	logic [15:0] rsv_tiles = 16'd0;
	logic [15:0] row_tiles = 16'd16;

	glyph_req_t   pending_reqs [$];
	glyph_res_t   awaited_results [$];
	glyph_req_t   cur_req, next_req;
	logic [63:0]  key_pool_lo [$];
	logic [63:0]  key_pool_hi [$];
	bit           quiet = 1'b0;
	int           errors = 0;
	int           n_lookups = 0, n_hits = 0, n_full = 0, n_updates = 0, n_rebuilds = 0;
	int           cycles = 0;

	function automatic void clear_table();
		int row, x, y;
		row = (row_tiles == 0) ? 1 : row_tiles;
		x = rsv_tiles % row;
		y = rsv_tiles / row;
		foreach (heads[s]) heads[s] = '0;
		for (int i = 0; i < ENTRY_COUNT; i++) begin
			if (x >= row) begin
				x = 0;
				y++;
			end
			chain_link[i] = (i + 1 < ENTRY_COUNT) ? 8'(i + 1) : 8'd0;
			mru_next[i] = '0;
			mru_prev[i] = '0;
			tile_pos[i] = {16'(y), 16'(x)};
			fill_mem[i] = '0;
			width_mem[i] = '0;
			height_mem[i] = '0;
			x++;
		end
	endfunction

	function automatic glyph_res_t entry_result(int idx, logic hit);
		glyph_res_t r;
		r.idx = 8'(idx);
		r.hit = hit;
		r.full = 1'b0;
		r.tx = tile_pos[idx][15:0];
		r.ty = tile_pos[idx][31:16];
		r.fill = fill_mem[idx];
		r.w = width_mem[idx];
		r.h = height_mem[idx];
		return r;
	endfunction

	function automatic glyph_res_t find_or_alloc(logic [63:0] klo, logic [63:0] khi);
		int slot, idx, steps, p, n, head;
		logic hit;
		glyph_res_t r;
		slot = klo[SLOT_W-1:0];
		idx = heads[slot];
		steps = 0;
		hit = 1'b0;
		while (idx != 0 && !hit && steps < ENTRY_COUNT) begin
			if (key_lo_mem[idx] == klo && key_hi_mem[idx] == khi)
				hit = 1'b1;
			else begin
				idx = chain_link[idx];
				steps++;
			end
		end
		if (hit) begin
			p = mru_prev[idx];
			n = mru_next[idx];
			mru_next[p] = 8'(n);
			mru_prev[n] = 8'(p);
			n_hits++;
		end else begin
			idx = chain_link[0];
			if (idx == 0) begin
				r = '0;
				r.full = 1'b1;
				n_full++;
				return r;
			end
			chain_link[0] = chain_link[idx];
			chain_link[idx] = heads[slot];
			key_lo_mem[idx] = klo;
			key_hi_mem[idx] = khi;
			heads[slot] = 8'(idx);
		end
		head = mru_next[0];
		mru_next[idx] = 8'(head);
		mru_prev[idx] = '0;
		mru_prev[head] = 8'(idx);
		mru_next[0] = 8'(idx);
		return entry_result(idx, hit);
	endfunction

	function automatic glyph_res_t predict_result(glyph_req_t q);
		glyph_res_t r;
		r = '0;
		case (q.op)
			OP_LOOKUP: begin
				n_lookups++;
				r = find_or_alloc(q.klo, q.khi);
			end
			OP_UPDATE: begin
				n_updates++;
				fill_mem[q.tgt] = q.fill;
				width_mem[q.tgt] = q.w;
				height_mem[q.tgt] = q.h;
				r = entry_result(q.tgt, 1'b0);
			end
			OP_REBUILD: begin
				n_rebuilds++;
				clear_table();
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0h expected %0h", what, got, want);
		errors++;
	endtask

	// stream driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				awaited_results.push_back(predict_result(cur_req));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_reqs.size() > 0 && (quiet || $urandom_range(99) >= 29)) begin
					next_req = pending_reqs.pop_front();
					cur_req <= next_req;
					s_axis_tvalid <= 1'b1;
					s_axis_tuser <= next_req.op;
					s_axis_tdata <= {next_req.h, next_req.w, next_req.fill, next_req.tgt,
						next_req.khi, next_req.klo};
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (awaited_results.size() == 0) begin
					report_mismatch("unexpected transfer", m_axis_tdata[63:0], 64'd0);
				end else begin
					glyph_res_t e;
					e = awaited_results.pop_front();
					if (m_axis_tdata[7:0] != e.idx)
						report_mismatch("entry_index", m_axis_tdata[7:0], e.idx);
					if (m_axis_tuser[0] != e.hit)
						report_mismatch("was_hit", m_axis_tuser[0], e.hit);
					if (m_axis_tuser[1] != e.full)
						report_mismatch("table_full", m_axis_tuser[1], e.full);
					if (m_axis_tdata[23:8] != e.tx)
						report_mismatch("tile_x", m_axis_tdata[23:8], e.tx);
					if (m_axis_tdata[39:24] != e.ty)
						report_mismatch("tile_y", m_axis_tdata[39:24], e.ty);
					if (m_axis_tdata[47:40] != e.fill)
						report_mismatch("fill_state", m_axis_tdata[47:40], e.fill);
					if (m_axis_tdata[63:48] != e.w)
						report_mismatch("glyph_width", m_axis_tdata[63:48], e.w);
					if (m_axis_tdata[79:64] != e.h)
						report_mismatch("glyph_height", m_axis_tdata[79:64], e.h);
				end
			end
			m_axis_tready <= quiet || ($urandom_range(99) >= 29);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("tb: failure");
			$finish;
		end
	end

	function automatic glyph_req_t make_req(opcode_t op, logic [63:0] klo, logic [63:0] khi,
			logic [7:0] tgt, logic [7:0] fill, logic [15:0] w, logic [15:0] h);
		glyph_req_t q;
		q.op = op; q.klo = klo; q.khi = khi; q.tgt = tgt;
		q.fill = fill; q.w = w; q.h = h;
		return q;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// random mix; slot_span narrows the slots so chains grow long
	task automatic add_random(int n, int slot_span, int lookup_pct);
		glyph_req_t q;
		int r, k;
		for (int i = 0; i < n; i++) begin
			q = make_req(OP_NONE, rand64(), rand64(), 8'($urandom()), 8'($urandom()),
				16'($urandom()), 16'($urandom()));
			r = $urandom_range(99);
			if (r < lookup_pct) begin
				q.op = OP_LOOKUP;
				if (key_pool_lo.size() > 0 && $urandom_range(1)) begin
					k = $urandom_range(key_pool_lo.size() - 1);
					q.klo = key_pool_lo[k];
					q.khi = key_pool_hi[k];
				end else begin
					q.klo[SLOT_W-1:0] = SLOT_W'($urandom_range(slot_span - 1));
					key_pool_lo.push_back(q.klo);
					key_pool_hi.push_back(q.khi);
				end
			end else if (r < 94) begin
				q.op = OP_UPDATE;
			end else if (r < 97) begin
				q.op = OP_NONE;
			end else begin
				q.op = OP_REBUILD;
			end
			pending_reqs.push_back(q);
		end
	endtask

	// sampled on the falling edge so the driver's updates have settled
	task automatic drain();
		do @(negedge clk);
		while (pending_reqs.size() > 0 || s_axis_tvalid || awaited_results.size() > 0);
		repeat (20) @(posedge clk);
	endtask

	// consecutive writes keep cfg_valid high
	task automatic write_reg(reg_idx_t idx, logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk);
		while (!cfg_ready);
		if (idx == REG_RESERVED) rsv_tiles = value;
		else row_tiles = value;
	endtask

	task automatic new_layout(logic [15:0] reserved, logic [15:0] row);
		write_reg(REG_RESERVED, reserved);
		write_reg(REG_ROW, row);
		cfg_valid <= 1'b0;
		pending_reqs.push_back(make_req(OP_REBUILD, '0, '0, '0, '0, '0, '0));
		key_pool_lo.delete();
		key_pool_hi.delete();
	endtask

	initial begin
		logic [63:0] c0, c1, c2;
		clear_table();
		foreach (key_lo_mem[i]) begin
			key_lo_mem[i] = '0;
			key_hi_mem[i] = '0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extreme keys, hits, a same-slot chain with a hit in the middle
		c0 = 64'h1234_5678_9abc_de05;
		c1 = 64'hfedc_ba98_7654_3205;
		c2 = 64'h0f0f_0f0f_0f0f_0f05;
		pending_reqs.push_back(make_req(OP_LOOKUP, '0, '0, '0, '0, '0, '0));
		pending_reqs.push_back(make_req(OP_LOOKUP, '1, '1, '1, '1, '1, '1));
		pending_reqs.push_back(make_req(OP_LOOKUP, '0, '0, '0, '0, '0, '0));
		pending_reqs.push_back(make_req(OP_LOOKUP, '0, '1, '0, '0, '0, '0));
		pending_reqs.push_back(make_req(OP_LOOKUP, c0, '0, '0, '0, '0, '0));
		pending_reqs.push_back(make_req(OP_LOOKUP, c1, '0, '0, '0, '0, '0));
		pending_reqs.push_back(make_req(OP_LOOKUP, c2, '0, '0, '0, '0, '0));
		pending_reqs.push_back(make_req(OP_LOOKUP, c1, '0, '0, '0, '0, '0));
		pending_reqs.push_back(make_req(OP_LOOKUP, c0, '0, '0, '0, '0, '0));
		pending_reqs.push_back(make_req(OP_UPDATE, '0, '0, 8'd0, '1, '1, '1));
		pending_reqs.push_back(make_req(OP_UPDATE, '1, '1, 8'd255, '1, '1, '1));
		pending_reqs.push_back(make_req(OP_UPDATE, '0, '0, 8'd1, 8'h5a, 16'd0, 16'hffff));
		pending_reqs.push_back(make_req(OP_UPDATE, '0, '0, 8'd200, '0, '0, '0));
		pending_reqs.push_back(make_req(OP_LOOKUP, '1, '1, '0, '0, '0, '0));
		pending_reqs.push_back(make_req(OP_NONE, '1, '1, '1, '1, '1, '1));
		pending_reqs.push_back(make_req(OP_REBUILD, '1, '1, '1, '1, '1, '1));
		pending_reqs.push_back(make_req(OP_LOOKUP, c0, '0, '0, '0, '0, '0));
		drain();

		// single tile per row with the largest reservation: rows wrap
		new_layout(16'hffff, 16'd1);
		add_random(200, 4, 70);
		drain();

		// zero row width; fill the table until misses report full
		new_layout(16'd0, 16'd0);
		for (int i = 0; i < 262; i++)
			pending_reqs.push_back(make_req(OP_LOOKUP, rand64(), rand64(), '0, '0, '0, '0));
		add_random(40, 64, 90);
		drain();

		// widest rows, no idling on either side
		quiet = 1'b1;
		new_layout(16'hffff, 16'hffff);
		add_random(200, 64, 70);
		drain();
		quiet = 1'b0;

		// random layout, very long chains in two slots
		new_layout(16'($urandom()), 16'($urandom_range(1, 40)));
		add_random(200, 2, 75);
		drain();
		repeat (50) @(posedge clk);

		if (awaited_results.size() != 0)
			report_mismatch("results never delivered", awaited_results.size(), 0);
		$display("covered %0d lookups (%0d hits, %0d full), %0d updates, %0d rebuilds",
			n_lookups, n_hits, n_full, n_updates, n_rebuilds);
		$display("layouts: reset, max reservation, zero row, max row, random; %0d mismatches",
			errors);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

@@ files.f @@
src/glc_pkg.sv
src/glyph_cache_hash_lru_table.sv
verif/tb_glyph_cache_hash_lru_table.sv
